// ----- rtl/sfd_pkg.sv -----
package sfd_pkg;

   // Framing bytes
   localparam logic [7:0]  FLAG_BEGIN = 8'h7E;
   localparam logic [7:0]  FLAG_ESC   = 8'h7D;
   localparam logic [7:0]  ESC_XOR    = 8'h20;
   // Reflected CRC-16 polynomial (table entries 0xC0C1 ... 0x4040)
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   // Configuration register indexes
   localparam logic CSR_LOCAL_ADDR = 1'b0;
   localparam logic CSR_MAX_LEN    = 1'b1;
   localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

   // Result event codes
   typedef enum logic [1:0] {
      EV_DATA    = 2'd0,
      EV_GOOD    = 2'd1,
      EV_CRC_ERR = 2'd2,
      EV_LEN_ERR = 2'd3
   } event_type;

   // Deframer phase, one-hot
   typedef enum logic [7:0] {
      PH_IDLE    = 8'b0000_0001,
      PH_SRC     = 8'b0000_0010,
      PH_DST     = 8'b0000_0100,
      PH_LEN_LO  = 8'b0000_1000,
      PH_LEN_HI  = 8'b0001_0000,
      PH_PAYLOAD = 8'b0010_0000,
      PH_CRC_LO  = 8'b0100_0000,
      PH_CRC_HI  = 8'b1000_0000
   } phase_type;

   // One result beat
   typedef struct packed {
      logic [15:0] frame_length;
      logic [7:0]  source_address;
      logic [7:0]  data_byte;
      event_type   event_res;
   } result_type;

   localparam int RESULT_W = $bits(result_type);
   localparam int RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

   // Byte-wide reflected CRC-16 update, eight bit steps
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/sfd_parser.sv -----
module sfd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat_valid,
   input  logic [7:0]          raw_byte,
   input  logic [7:0]          local_address,
   input  logic [15:0]         max_payload_length,
   output logic                res_valid,
   output sfd_pkg::result_type res
);
   import sfd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        esc_ff, esc_in;
   logic [7:0]  src_ff, src_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;

   logic        have_oct;
   logic [7:0]  oct;
   logic [15:0] len_full;
   logic [15:0] pos_next;
   logic [15:0] rx_crc;

   // Unescape: decide whether this byte carries a frame octet
   always_comb begin
      have_oct = 1'b0;
      oct      = raw_byte;
      if (phase_ff != PH_IDLE) begin
         if (esc_ff) begin
            have_oct = (raw_byte != FLAG_BEGIN);
            oct      = raw_byte ^ ESC_XOR;
         end else begin
            have_oct = (raw_byte != FLAG_ESC) && (raw_byte != FLAG_BEGIN);
         end
      end
   end

   assign len_full = {oct, len_ff[7:0]};
   assign pos_next = pos_ff + 16'd1;
   assign rx_crc   = {oct, crc_lo_ff};

   // Next state and result
   always_comb begin
      phase_in  = phase_ff;
      esc_in    = esc_ff;
      src_in    = src_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      crc_lo_in = crc_lo_ff;
      res_valid = 1'b0;
      res.event_res      = EV_DATA;
      res.data_byte      = 8'h00;
      res.source_address = src_ff;
      res.frame_length   = len_ff;

      if (beat_valid) begin
         if (phase_ff == PH_IDLE) begin
            esc_in = 1'b0;
            if (raw_byte == FLAG_BEGIN) phase_in = PH_SRC;
         end else if (!have_oct) begin
            // escape byte, or a begin flag (plain or escaped) restarting the frame
            if (!esc_ff && raw_byte == FLAG_ESC) begin
               esc_in = 1'b1;
            end else begin
               esc_in   = 1'b0;
               phase_in = PH_SRC;
            end
         end else begin
            esc_in = 1'b0;
            case (phase_ff)
               PH_SRC: begin
                  src_in   = oct;
                  phase_in = PH_DST;
               end
               PH_DST: begin
                  phase_in = (oct == local_address) ? PH_LEN_LO : PH_IDLE;
               end
               PH_LEN_LO: begin
                  len_in   = {8'h00, oct};
                  phase_in = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  len_in = len_full;
                  pos_in = 16'd0;
                  crc_in = 16'd0;
                  res.frame_length = len_full;
                  if (len_full > max_payload_length) begin
                     phase_in      = PH_IDLE;
                     res_valid     = 1'b1;
                     res.event_res = EV_LEN_ERR;
                  end else begin
                     phase_in = (len_full == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  crc_in = crc16_byte(crc_ff, oct);
                  pos_in = pos_next;
                  if (pos_next >= len_ff) phase_in = PH_CRC_LO;
                  res_valid     = 1'b1;
                  res.event_res = EV_DATA;
                  res.data_byte = oct;
               end
               PH_CRC_LO: begin
                  crc_lo_in = oct;
                  phase_in  = PH_CRC_HI;
               end
               PH_CRC_HI: begin
                  phase_in      = PH_IDLE;
                  res_valid     = 1'b1;
                  res.event_res = (rx_crc == crc_ff) ? EV_GOOD : EV_CRC_ERR;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         esc_ff    <= 1'b0;
         src_ff    <= 8'h00;
         len_ff    <= 16'd0;
         pos_ff    <= 16'd0;
         crc_ff    <= 16'd0;
         crc_lo_ff <= 8'h00;
      end else begin
         phase_ff  <= phase_in;
         esc_ff    <= esc_in;
         src_ff    <= src_in;
         len_ff    <= len_in;
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
      end
   end

endmodule

// ----- rtl/sfd_out_buf.sv -----
module sfd_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  sfd_pkg::result_type in_res,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output sfd_pkg::result_type out_res,
   output logic                skid_valid
);
   import sfd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_res_ff, out_res_in;
   result_type skid_res_ff, skid_res_in;
   logic       out_free;

   assign out_free = !out_valid_ff || out_ready;
   assign in_ready = !skid_valid_ff;

   // Output register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_res_in    = out_res_ff;
      skid_valid_in = skid_valid_ff;
      skid_res_in   = skid_res_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_res_in    = skid_res_ff;
            skid_valid_in = in_valid;
            skid_res_in   = in_res;
         end else begin
            out_valid_in = in_valid;
            out_res_in   = in_res;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_res_in   = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_res    = out_res_ff;
   assign skid_valid = skid_valid_ff;

endmodule

// ----- rtl/serial_frame_deframer_crc16_top.sv -----
// Channel | Direction | Fields (lowest bit first)
// req     | in        | tdata: raw_byte[7:0]
// rsp     | out       | tdata: event_res[1:0], data_byte[9:2], source_address[17:10],
//         |           |        frame_length[33:18], zero fill [39:34]
// csr     | in        | csr_addr 0 local_address, 1 max_payload_length; csr_wdata 16 bits
//
// One serial byte per cycle while req_tready is high: the unescape, phase update and
// byte-wide CRC step run from the frame state registers into the result register.
// A result is registered in the output buffer before it appears on rsp.
// Reset is synchronous; it clears the phase, the escape flag and both buffer slots.
// A skid entry behind the result register keeps req_tready high for one
// more beat while rsp is stalled; req_tready drops only when both are full.
module serial_frame_deframer_crc16_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // raw_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // event_res, data_byte, source_address, frame_length
   input  logic        csr_wen,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);
   import sfd_pkg::*;

   logic [7:0]  local_addr_ff;
   logic [15:0] max_len_ff;
   logic        beat;
   logic        res_valid;
   result_type  res;
   result_type  out_res;
   logic        skid_valid;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= 8'h00;
         max_len_ff    <= MAX_LEN_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_LOCAL_ADDR: local_addr_ff <= csr_wdata[7:0];
            CSR_MAX_LEN:    max_len_ff    <= csr_wdata;
            default:        ;
         endcase
      end
   end

   assign beat = req_tvalid && req_tready;

   sfd_parser u_parser (
      .clock              (clock),
      .reset              (reset),
      .beat_valid         (beat),
      .raw_byte           (req_tdata),
      .local_address      (local_addr_ff),
      .max_payload_length (max_len_ff),
      .res_valid          (res_valid),
      .res                (res)
   );

   sfd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (res_valid),
      .in_res     (res),
      .in_ready   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_res    (out_res),
      .skid_valid (skid_valid)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RESULT_W){1'b0}}, out_res};

`ifndef SYNTHESIS
   // The skid entry only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid |-> rsp_tvalid)
      else $error("skid entry valid with empty output register");

   // Input stalls only when both slots hold results
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready) || skid_valid)
      else $error("input stalled without a pending result");

   // Non-payload results carry a zero data byte
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != EV_DATA) |-> rsp_tdata[9:2] == 8'h00)
      else $error("report beat with nonzero data byte");

   // A stalled result with a beat arriving lands in the skid entry
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && res_valid && beat) |=> skid_valid)
      else $error("result lost under output stall");
`endif

endmodule
